/* hw/rtl/dpcm_pkg.sv */
package dpcm_pkg;

  // field widths of the channels
  localparam int CMD_W   = 2;
  localparam int PAGE_W  = 13;
  localparam int RUN_W   = 6;
  localparam int STAT_W  = 2;
  localparam int FRAME_W = 11;
  localparam int CNT_W   = 32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_PAGE = 2'd2;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_ALLOC_BAD = 3'd1,
    OP_FREE      = 3'd2,
    OP_READ      = 3'd3,
    OP_WRITE     = 3'd4,
    OP_BAD_PAGE  = 3'd5
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [PAGE_W-1:0] page;
    logic [RUN_W-1:0]  run;
  } desc_t;

endpackage

/* hw/rtl/dpcm_ifs.sv */
interface dpcm_in_if;
  logic                         valid;
  logic                         ready;
  logic [dpcm_pkg::CMD_W-1:0]   command;
  logic [dpcm_pkg::PAGE_W-1:0]  page_number;
  logic [dpcm_pkg::RUN_W-1:0]   run_pages;

  modport source (output valid, command, page_number, run_pages, input ready);
  modport sink   (input valid, command, page_number, run_pages, output ready);
endinterface

interface dpcm_out_if;
  logic                         valid;
  logic                         ready;
  logic [dpcm_pkg::STAT_W-1:0]  status;
  logic [dpcm_pkg::PAGE_W-1:0]  page_out;
  logic [dpcm_pkg::FRAME_W-1:0] frame_out;
  logic                         loaded_from_swap;
  logic                         victim_valid;
  logic [dpcm_pkg::PAGE_W-1:0]  victim_page;
  logic                         victim_written_back;
  logic                         last_of_run;
  logic [dpcm_pkg::CNT_W-1:0]   hit_total;
  logic [dpcm_pkg::CNT_W-1:0]   miss_total;
  logic [dpcm_pkg::CNT_W-1:0]   writeback_total;

  modport source (output valid, status, page_out, frame_out, loaded_from_swap,
                  victim_valid, victim_page, victim_written_back, last_of_run,
                  hit_total, miss_total, writeback_total, input ready);
  modport sink   (input valid, status, page_out, frame_out, loaded_from_swap,
                  victim_valid, victim_page, victim_written_back, last_of_run,
                  hit_total, miss_total, writeback_total, output ready);
endinterface

/* hw/rtl/demand_paging_clock_manager.sv */
// Page table and frame manager with clock replacement.
// in_ch takes one command item (allocate run, free run, read, write) on each
// valid/ready handshake; out_ch gives one result item per handshake, one per
// page for a successful allocate and one for every other command, the final
// one marked by last_of_run. A two-entry queue sits between the classifying
// front end and the table engine, so new items are taken while a result
// waits on out_ch.
// Steps per item, all table accesses through one read port per table:
//   bad length: the result only; hit or bad page: at most one page table read
//   free: read the start page, then read and release each page of the run
//   allocate: scan pages for a free run, then per page scan frames for the
//   lowest free frame, plus when all frames are used step the clock hand
//   and evict, then give the result
//   read/write miss: as one allocated page
// A stall on out_ch holds the result and the engine; the queue then fills
// and in_ch.ready drops.
// After reset both tables are swept to zero, one entry a cycle over
// max(NUM_PAGES, NUM_FRAMES) entries (8192 by default); in_ch.ready stays low.
module demand_paging_clock_manager #(
  parameter int NUM_PAGES  = 8192,
  parameter int NUM_FRAMES = 2048,
  parameter int MAX_RUN    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  dpcm_in_if.sink     in_ch,
  dpcm_out_if.source  out_ch
);

  dpcm_pkg::desc_t q_din, q_dout;
  logic q_push, q_full, q_pop, q_valid, busy;

  dpcm_front #(
    .NUM_PAGES (NUM_PAGES),
    .MAX_RUN   (MAX_RUN)
  ) u_front (
    .in_ch  (in_ch),
    .busy   (busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_din  (q_din)
  );

  dpcm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  dpcm_back #(
    .NUM_PAGES  (NUM_PAGES),
    .NUM_FRAMES (NUM_FRAMES),
    .MAX_RUN    (MAX_RUN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_dout  (q_dout),
    .q_pop   (q_pop),
    .busy    (busy),
    .out_ch  (out_ch)
  );

endmodule

/* hw/rtl/dpcm_front.sv */
module dpcm_front #(
  parameter int NUM_PAGES = 8192,
  parameter int MAX_RUN   = 32
) (
  dpcm_in_if.sink          in_ch,
  input  logic             busy,
  input  logic             q_full,
  output logic             q_push,
  output dpcm_pkg::desc_t  q_din
);

  logic page_bad;
  logic run_bad;

  // range checks on the incoming item
  assign page_bad = int'(in_ch.page_number) >= NUM_PAGES;
  assign run_bad  = (in_ch.run_pages == '0) || (int'(in_ch.run_pages) > MAX_RUN) ||
                    (int'(in_ch.run_pages) > NUM_PAGES);

  // classify the command
  always_comb begin
    q_din.page = in_ch.page_number;
    q_din.run  = in_ch.run_pages;
    case (in_ch.command)
      dpcm_pkg::CMD_ALLOC: q_din.op = run_bad ? dpcm_pkg::OP_ALLOC_BAD : dpcm_pkg::OP_ALLOC;
      dpcm_pkg::CMD_FREE:  q_din.op = page_bad ? dpcm_pkg::OP_BAD_PAGE : dpcm_pkg::OP_FREE;
      dpcm_pkg::CMD_READ:  q_din.op = page_bad ? dpcm_pkg::OP_BAD_PAGE : dpcm_pkg::OP_READ;
      dpcm_pkg::CMD_WRITE: q_din.op = page_bad ? dpcm_pkg::OP_BAD_PAGE : dpcm_pkg::OP_WRITE;
      default:             q_din.op = dpcm_pkg::OP_BAD_PAGE;
    endcase
  end

  // accept while the queue has room and the tables are not being cleared
  assign in_ch.ready = !busy && !q_full;
  assign q_push      = in_ch.valid && in_ch.ready;

endmodule

/* hw/rtl/dpcm_fifo.sv */
module dpcm_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dpcm_pkg::desc_t  din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output dpcm_pkg::desc_t  dout
);

  dpcm_pkg::desc_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign dout  = mem_r[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

/* hw/rtl/dpcm_back.sv */
module dpcm_back #(
  parameter int NUM_PAGES  = 8192,
  parameter int NUM_FRAMES = 2048,
  parameter int MAX_RUN    = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  dpcm_pkg::desc_t  q_dout,
  output logic             q_pop,
  output logic             busy,
  dpcm_out_if.source       out_ch
);

  localparam int PA_W  = $clog2(NUM_PAGES);
  localparam int FA_W  = $clog2(NUM_FRAMES);
  localparam int RL_W  = $clog2(MAX_RUN + 1);
  localparam int CLR_N = (NUM_PAGES > NUM_FRAMES) ? NUM_PAGES : NUM_FRAMES;
  localparam int CLR_W = $clog2(CLR_N);
  localparam logic [PA_W-1:0]  PG_LAST  = PA_W'(NUM_PAGES - 1);
  localparam logic [FA_W-1:0]  FR_LAST  = FA_W'(NUM_FRAMES - 1);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);

  typedef struct packed {
    logic            valid;
    logic            present;
    logic            dirty;
    logic [RL_W-1:0] run_len;
    logic [FA_W-1:0] frame;
  } pword_t;

  typedef struct packed {
    logic            used;
    logic            use_bit;
    logic [PA_W-1:0] owner;
  } fword_t;

  typedef enum logic [17:0] {
    S_CLEAR  = 18'h00001,
    S_IDLE   = 18'h00002,
    S_AS_RD  = 18'h00004,
    S_AS_EV  = 18'h00008,
    S_AC_RD  = 18'h00010,
    S_AC_EV  = 18'h00020,
    S_FS_RD  = 18'h00040,
    S_FS_EV  = 18'h00080,
    S_FR_RD  = 18'h00100,
    S_FR_EV  = 18'h00200,
    S_TF_RD  = 18'h00400,
    S_TF_EV  = 18'h00800,
    S_CK_RD  = 18'h01000,
    S_CK_EV  = 18'h02000,
    S_VIC_RD = 18'h04000,
    S_VIC_EV = 18'h08000,
    S_TF_WR  = 18'h10000,
    S_OUT    = 18'h20000
  } state_t;

  // page table and frame table memories
  pword_t pmem [NUM_PAGES];
  fword_t fmem [NUM_FRAMES];
  pword_t pm_rd_r;
  fword_t fm_rd_r;
  logic            pm_we, fm_we;
  logic [PA_W-1:0] pm_waddr, pm_raddr;
  logic [FA_W-1:0] fm_waddr, fm_raddr;
  pword_t          pm_wdata;
  fword_t          fm_wdata;

  state_t state_r, state_nxt;
  logic [CLR_W-1:0] clr_r, clr_nxt;
  dpcm_pkg::op_t    op_r, op_nxt;
  logic [PA_W-1:0]  cur_r, cur_nxt;
  logic [PA_W-1:0]  scan_r, scan_nxt;
  logic [PA_W-1:0]  vown_r, vown_nxt;
  logic [RL_W-1:0]  n_r, n_nxt;
  logic [RL_W-1:0]  j_r, j_nxt;
  logic [RL_W-1:0]  run_r, run_nxt;
  logic [RL_W-1:0]  rl_old_r, rl_old_nxt;
  logic [FA_W-1:0]  fscan_r, fscan_nxt;
  logic [FA_W-1:0]  hand_r, hand_nxt;
  logic [FA_W-1:0]  f_r, f_nxt;
  logic [FA_W-1:0]  hand_step;
  logic [dpcm_pkg::CNT_W-1:0]   hit_r, hit_nxt, miss_r, miss_nxt, wb_r, wb_nxt;
  logic [dpcm_pkg::STAT_W-1:0]  st_r, st_nxt;
  logic [dpcm_pkg::PAGE_W-1:0]  opg_r, opg_nxt, vp_r, vp_nxt;
  logic [dpcm_pkg::FRAME_W-1:0] ofr_r, ofr_nxt;
  logic ld_r, ld_nxt, last_r, last_nxt, vv_r, vv_nxt, vw_r, vw_nxt;

  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pm_waddr] <= pm_wdata;
    end
    pm_rd_r <= pmem[pm_raddr];
  end

  always_ff @(posedge clk) begin
    if (fm_we) begin
      fmem[fm_waddr] <= fm_wdata;
    end
    fm_rd_r <= fmem[fm_raddr];
  end

  // clock hand advance with wrap
  assign hand_step = (hand_r == FR_LAST) ? '0 : hand_r + FA_W'(1);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    cur_nxt    = cur_r;
    scan_nxt   = scan_r;
    vown_nxt   = vown_r;
    n_nxt      = n_r;
    j_nxt      = j_r;
    run_nxt    = run_r;
    rl_old_nxt = rl_old_r;
    fscan_nxt  = fscan_r;
    hand_nxt   = hand_r;
    f_nxt      = f_r;
    hit_nxt    = hit_r;
    miss_nxt   = miss_r;
    wb_nxt     = wb_r;
    st_nxt     = st_r;
    opg_nxt    = opg_r;
    ofr_nxt    = ofr_r;
    ld_nxt     = ld_r;
    last_nxt   = last_r;
    vv_nxt     = vv_r;
    vp_nxt     = vp_r;
    vw_nxt     = vw_r;
    pm_we      = 1'b0;
    pm_waddr   = cur_r;
    pm_wdata   = '0;
    pm_raddr   = cur_r;
    fm_we      = 1'b0;
    fm_waddr   = f_r;
    fm_wdata   = '0;
    fm_raddr   = fscan_r;
    q_pop      = 1'b0;

    case (state_r)
      // zero both tables after reset
      S_CLEAR: begin
        pm_we    = int'(clr_r) < NUM_PAGES;
        pm_waddr = PA_W'(clr_r);
        fm_we    = int'(clr_r) < NUM_FRAMES;
        fm_waddr = FA_W'(clr_r);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + CLR_W'(1);
        end
      end

      // take the next item from the queue
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          op_nxt   = q_dout.op;
          cur_nxt  = PA_W'(q_dout.page);
          n_nxt    = RL_W'(q_dout.run);
          opg_nxt  = q_dout.page;
          st_nxt   = dpcm_pkg::ST_OK;
          ofr_nxt  = '0;
          ld_nxt   = 1'b0;
          last_nxt = 1'b1;
          vv_nxt   = 1'b0;
          vp_nxt   = '0;
          vw_nxt   = 1'b0;
          case (q_dout.op)
            dpcm_pkg::OP_ALLOC: begin
              scan_nxt  = '0;
              run_nxt   = '0;
              state_nxt = S_AS_RD;
            end
            dpcm_pkg::OP_ALLOC_BAD: begin
              st_nxt    = dpcm_pkg::ST_NO_SPACE;
              opg_nxt   = '0;
              state_nxt = S_OUT;
            end
            dpcm_pkg::OP_FREE: state_nxt = S_FS_RD;
            dpcm_pkg::OP_READ, dpcm_pkg::OP_WRITE: state_nxt = S_AC_RD;
            default: begin
              st_nxt    = dpcm_pkg::ST_BAD_PAGE;
              state_nxt = S_OUT;
            end
          endcase
        end
      end

      // search for the first run of free pages
      S_AS_RD: begin
        pm_raddr  = scan_r;
        state_nxt = S_AS_EV;
      end
      S_AS_EV: begin
        if (!pm_rd_r.valid && (run_r + RL_W'(1) == n_r)) begin
          cur_nxt   = scan_r - PA_W'(n_r - RL_W'(1));
          j_nxt     = '0;
          fscan_nxt = '0;
          state_nxt = S_TF_RD;
        end else begin
          run_nxt = pm_rd_r.valid ? '0 : run_r + RL_W'(1);
          if (scan_r == PG_LAST) begin
            st_nxt    = dpcm_pkg::ST_NO_SPACE;
            opg_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            scan_nxt  = scan_r + PA_W'(1);
            state_nxt = S_AS_RD;
          end
        end
      end

      // read or write access
      S_AC_RD: begin
        pm_raddr  = cur_r;
        state_nxt = S_AC_EV;
      end
      S_AC_EV: begin
        if (!pm_rd_r.valid) begin
          st_nxt    = dpcm_pkg::ST_BAD_PAGE;
          state_nxt = S_OUT;
        end else if (pm_rd_r.present) begin
          hit_nxt  = hit_r + 32'd1;
          fm_we    = 1'b1;
          fm_waddr = pm_rd_r.frame;
          fm_wdata = '{used: 1'b1, use_bit: 1'b1, owner: cur_r};
          if (op_r == dpcm_pkg::OP_WRITE) begin
            pm_we          = 1'b1;
            pm_wdata       = pm_rd_r;
            pm_wdata.dirty = 1'b1;
          end
          ofr_nxt   = dpcm_pkg::FRAME_W'(pm_rd_r.frame);
          state_nxt = S_OUT;
        end else begin
          miss_nxt   = miss_r + 32'd1;
          rl_old_nxt = pm_rd_r.run_len;
          fscan_nxt  = '0;
          state_nxt  = S_TF_RD;
        end
      end

      // free: check the start page
      S_FS_RD: begin
        pm_raddr  = cur_r;
        state_nxt = S_FS_EV;
      end
      S_FS_EV: begin
        if (!pm_rd_r.valid || pm_rd_r.run_len == '0) begin
          st_nxt    = dpcm_pkg::ST_BAD_PAGE;
          state_nxt = S_OUT;
        end else begin
          n_nxt     = pm_rd_r.run_len;
          j_nxt     = '0;
          state_nxt = S_FR_RD;
        end
      end

      // free: release one page of the run
      S_FR_RD: begin
        pm_raddr  = cur_r;
        state_nxt = S_FR_EV;
      end
      S_FR_EV: begin
        if (pm_rd_r.present) begin
          fm_we    = 1'b1;
          fm_waddr = pm_rd_r.frame;
        end
        pm_we = 1'b1;
        if ((j_r + RL_W'(1) == n_r) || (cur_r == PG_LAST)) begin
          state_nxt = S_OUT;
        end else begin
          cur_nxt   = cur_r + PA_W'(1);
          j_nxt     = j_r + RL_W'(1);
          state_nxt = S_FR_RD;
        end
      end

      // lowest free frame scan
      S_TF_RD: begin
        fm_raddr  = fscan_r;
        state_nxt = S_TF_EV;
      end
      S_TF_EV: begin
        if (!fm_rd_r.used) begin
          f_nxt     = fscan_r;
          state_nxt = S_TF_WR;
        end else if (fscan_r == FR_LAST) begin
          state_nxt = S_CK_RD;
        end else begin
          fscan_nxt = fscan_r + FA_W'(1);
          state_nxt = S_TF_RD;
        end
      end

      // clock sweep for a victim
      S_CK_RD: begin
        fm_raddr  = hand_step;
        hand_nxt  = hand_step;
        state_nxt = S_CK_EV;
      end
      S_CK_EV: begin
        if (fm_rd_r.use_bit) begin
          fm_we            = 1'b1;
          fm_waddr         = hand_r;
          fm_wdata         = fm_rd_r;
          fm_wdata.use_bit = 1'b0;
          state_nxt        = S_CK_RD;
        end else begin
          f_nxt     = hand_r;
          vown_nxt  = fm_rd_r.owner;
          vv_nxt    = 1'b1;
          vp_nxt    = dpcm_pkg::PAGE_W'(fm_rd_r.owner);
          state_nxt = S_VIC_RD;
        end
      end

      // evict the victim page
      S_VIC_RD: begin
        pm_raddr  = vown_r;
        state_nxt = S_VIC_EV;
      end
      S_VIC_EV: begin
        vw_nxt = pm_rd_r.dirty;
        if (pm_rd_r.dirty) begin
          wb_nxt = wb_r + 32'd1;
        end
        pm_we            = 1'b1;
        pm_waddr         = vown_r;
        pm_wdata         = pm_rd_r;
        pm_wdata.present = 1'b0;
        pm_wdata.dirty   = 1'b0;
        state_nxt        = S_TF_WR;
      end

      // map the page to its frame
      S_TF_WR: begin
        fm_we            = 1'b1;
        fm_waddr         = f_r;
        fm_wdata         = '{used: 1'b1, use_bit: 1'b1, owner: cur_r};
        pm_we            = 1'b1;
        pm_waddr         = cur_r;
        pm_wdata.valid   = 1'b1;
        pm_wdata.present = 1'b1;
        pm_wdata.frame   = f_r;
        if (op_r == dpcm_pkg::OP_ALLOC) begin
          pm_wdata.dirty   = 1'b1;
          pm_wdata.run_len = (j_r == '0) ? n_r : '0;
          opg_nxt          = dpcm_pkg::PAGE_W'(cur_r);
          ld_nxt           = 1'b0;
          last_nxt         = j_r + RL_W'(1) == n_r;
        end else begin
          pm_wdata.dirty   = op_r == dpcm_pkg::OP_WRITE;
          pm_wdata.run_len = rl_old_r;
          ld_nxt           = 1'b1;
          last_nxt         = 1'b1;
        end
        ofr_nxt   = dpcm_pkg::FRAME_W'(f_r);
        state_nxt = S_OUT;
      end

      // hold the result until taken
      S_OUT: begin
        if (out_ch.ready) begin
          if (op_r == dpcm_pkg::OP_ALLOC && !last_r) begin
            cur_nxt   = cur_r + PA_W'(1);
            j_nxt     = j_r + RL_W'(1);
            fscan_nxt = '0;
            vv_nxt    = 1'b0;
            vp_nxt    = '0;
            vw_nxt    = 1'b0;
            state_nxt = S_TF_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      hand_r  <= FR_LAST;
      hit_r   <= '0;
      miss_r  <= '0;
      wb_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      hand_r  <= hand_nxt;
      hit_r   <= hit_nxt;
      miss_r  <= miss_nxt;
      wb_r    <= wb_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    cur_r    <= cur_nxt;
    scan_r   <= scan_nxt;
    vown_r   <= vown_nxt;
    n_r      <= n_nxt;
    j_r      <= j_nxt;
    run_r    <= run_nxt;
    rl_old_r <= rl_old_nxt;
    fscan_r  <= fscan_nxt;
    f_r      <= f_nxt;
    st_r     <= st_nxt;
    opg_r    <= opg_nxt;
    ofr_r    <= ofr_nxt;
    ld_r     <= ld_nxt;
    last_r   <= last_nxt;
    vv_r     <= vv_nxt;
    vp_r     <= vp_nxt;
    vw_r     <= vw_nxt;
  end

  // result channel
  assign busy                       = state_r == S_CLEAR;
  assign out_ch.valid               = state_r == S_OUT;
  assign out_ch.status              = st_r;
  assign out_ch.page_out            = opg_r;
  assign out_ch.frame_out           = ofr_r;
  assign out_ch.loaded_from_swap    = ld_r;
  assign out_ch.victim_valid        = vv_r;
  assign out_ch.victim_page         = vp_r;
  assign out_ch.victim_written_back = vw_r;
  assign out_ch.last_of_run         = last_r;
  assign out_ch.hit_total           = hit_r;
  assign out_ch.miss_total          = miss_r;
  assign out_ch.writeback_total     = wb_r;

  // failed results carry no frame, load or eviction
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && st_r != dpcm_pkg::ST_OK |-> ofr_r == '0 && !vv_r && !ld_r && last_r)
    else $error("failed result carries frame or victim data");

  // a hit and a miss are never counted together
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    !(hit_r != $past(hit_r) && miss_r != $past(miss_r)))
    else $error("hit and miss counted in one cycle");

  // the clock hand stays inside the frame table
  a_hand_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CK_EV |-> hand_r <= FR_LAST)
    else $error("clock hand out of range");

  // a write-back only follows a reported victim
  a_wb_victim: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && vw_r |-> vv_r && st_r == dpcm_pkg::ST_OK)
    else $error("write-back without a victim");

  // a popped item always starts work
  a_pop_work: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != S_IDLE && state_r != S_CLEAR)
    else $error("popped item was dropped");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int PAGES  = 8192;
  localparam int FRAMES = 2048;
  localparam int RUN_MAX = 32;

  typedef struct {
    logic [dpcm_pkg::STAT_W-1:0]  status;
    logic [dpcm_pkg::PAGE_W-1:0]  page;
    logic [dpcm_pkg::FRAME_W-1:0] frame;
    logic                         loaded;
    logic                         vic_valid;
    logic [dpcm_pkg::PAGE_W-1:0]  vic_page;
    logic                         vic_wb;
    logic                         last;
    logic [dpcm_pkg::CNT_W-1:0]   hits;
    logic [dpcm_pkg::CNT_W-1:0]   misses;
    logic [dpcm_pkg::CNT_W-1:0]   writebacks;
  } page_result_t;

  typedef struct {
    logic [dpcm_pkg::CMD_W-1:0]   cmd;
    logic [dpcm_pkg::PAGE_W-1:0]  page;
    logic [dpcm_pkg::RUN_W-1:0]   run;
    bit                           typed;
    logic [dpcm_pkg::STAT_W-1:0]  status;
    logic [dpcm_pkg::PAGE_W-1:0]  page_out;
    logic [dpcm_pkg::FRAME_W-1:0] frame_out;
  } stim_row_t;

  logic clk;
  logic rst_n;
  int   errors = 0;
  bit   quiet = 0;

  dpcm_in_if  in_ch ();
  dpcm_out_if out_ch ();

  demand_paging_clock_manager dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // clock
  initial clk = 0;
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // mirror of the page table and frame pool
  bit                           pv_valid [PAGES];
  bit                           pv_present [PAGES];
  bit                           pv_dirty [PAGES];
  bit [dpcm_pkg::RUN_W-1:0]     pv_run [PAGES];
  bit [dpcm_pkg::FRAME_W-1:0]   pv_frame [PAGES];
  bit [dpcm_pkg::PAGE_W-1:0]    fr_owner [FRAMES];
  bit                           fr_used [FRAMES];
  bit                           fr_ref [FRAMES];
  bit [dpcm_pkg::FRAME_W-1:0]   hand;
  bit [dpcm_pkg::CNT_W-1:0]     hit_cnt, miss_cnt, wb_cnt;
  bit                           ev_valid, ev_wb;
  bit [dpcm_pkg::PAGE_W-1:0]    ev_page;
  int                           run_starts[$];
  int                           mapped_pages = 0;
  int                           top_page = 0;

  page_result_t expected_results[$];

  function automatic void push_result(logic [dpcm_pkg::STAT_W-1:0] st, int page,
                                      int frame, bit loaded, bit last);
    page_result_t r;
    r.status = st;
    r.page = dpcm_pkg::PAGE_W'(page);
    r.frame = dpcm_pkg::FRAME_W'(frame);
    r.loaded = loaded;
    r.vic_valid = ev_valid; r.vic_page = ev_page; r.vic_wb = ev_wb;
    r.last = last; r.hits = hit_cnt; r.misses = miss_cnt; r.writebacks = wb_cnt;
    expected_results.push_back(r);
  endfunction

  // lowest free frame, else clock sweep victim
  function automatic int grab_frame(int page);
    int f;
    int v;
    bit found;
    f = 0;
    found = 0;
    ev_valid = 0; ev_page = 0; ev_wb = 0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!fr_used[i]) begin
        f = i; found = 1; break;
      end
    end
    if (!found) begin
      for (int i = 0; i < 2 * FRAMES + 1; i++) begin
        hand = hand + 1'b1;
        if (fr_ref[hand]) fr_ref[hand] = 0;
        else break;
      end
      f = hand;
      v = fr_owner[f];
      ev_valid = 1;
      ev_page = dpcm_pkg::PAGE_W'(v);
      ev_wb = pv_dirty[v];
      if (pv_dirty[v]) wb_cnt++;
      pv_present[v] = 0;
      pv_dirty[v] = 0;
    end
    fr_used[f] = 1;
    fr_ref[f] = 1;
    fr_owner[f] = dpcm_pkg::PAGE_W'(page);
    pv_frame[page] = dpcm_pkg::FRAME_W'(f);
    return f;
  endfunction

  // expected results of one command item
  function automatic void predict_command(logic [dpcm_pkg::CMD_W-1:0] cmd, int page,
                                          int n);
    int start;
    int len;
    int f;
    bit found;
    bit ok;
    start = 0;
    found = 0;
    ev_valid = 0; ev_page = 0; ev_wb = 0;
    case (cmd)
      dpcm_pkg::CMD_ALLOC: begin
        if (n >= 1 && n <= RUN_MAX) begin
          for (int i = 0; i + n <= PAGES; i++) begin
            ok = 1;
            for (int j = 0; j < n; j++)
              if (pv_valid[i + j]) begin
                ok = 0; break;
              end
            if (ok) begin
              start = i; found = 1; break;
            end
          end
        end
        if (!found) begin
          push_result(dpcm_pkg::ST_NO_SPACE, 0, 0, 0, 1);
        end else begin
          for (int j = 0; j < n; j++) begin
            pv_valid[start + j] = 1;
            pv_present[start + j] = 1;
            pv_dirty[start + j] = 1;
            pv_run[start + j] = (j == 0) ? dpcm_pkg::RUN_W'(n) : '0;
            f = grab_frame(start + j);
            push_result(dpcm_pkg::ST_OK, start + j, f, 0, j + 1 == n);
          end
          run_starts.push_back(start);
          mapped_pages += n;
          if (start + n > top_page) top_page = start + n;
        end
      end
      dpcm_pkg::CMD_FREE: begin
        if (!pv_valid[page] || pv_run[page] == 0) begin
          push_result(dpcm_pkg::ST_BAD_PAGE, page, 0, 0, 1);
        end else begin
          len = pv_run[page];
          for (int j = 0; j < len && page + j < PAGES; j++) begin
            if (pv_present[page + j]) begin
              fr_used[pv_frame[page + j]] = 0;
              fr_ref[pv_frame[page + j]] = 0;
            end
            pv_valid[page + j] = 0;
            pv_present[page + j] = 0;
            pv_dirty[page + j] = 0;
            pv_run[page + j] = 0;
          end
          mapped_pages -= len;
          foreach (run_starts[k])
            if (run_starts[k] == page) begin
              run_starts.delete(k); break;
            end
          push_result(dpcm_pkg::ST_OK, page, 0, 0, 1);
        end
      end
      default: begin
        if (!pv_valid[page]) begin
          push_result(dpcm_pkg::ST_BAD_PAGE, page, 0, 0, 1);
        end else if (pv_present[page]) begin
          hit_cnt++;
          fr_ref[pv_frame[page]] = 1;
          if (cmd == dpcm_pkg::CMD_WRITE) pv_dirty[page] = 1;
          push_result(dpcm_pkg::ST_OK, page, pv_frame[page], 0, 1);
        end else begin
          miss_cnt++;
          f = grab_frame(page);
          pv_present[page] = 1;
          pv_dirty[page] = (cmd == dpcm_pkg::CMD_WRITE);
          push_result(dpcm_pkg::ST_OK, page, f, 1, 1);
        end
      end
    endcase
  endfunction

  // present one item, wait for its handshake, then an optional gap
  task automatic send_item(logic [dpcm_pkg::CMD_W-1:0] cmd, int page, int n,
                           bit typed = 0,
                           logic [dpcm_pkg::STAT_W-1:0] st = dpcm_pkg::ST_OK,
                           int page_out = 0, int frame_out = 0);
    int gap;
    page_result_t r;
    in_ch.valid       <= 1;
    in_ch.command     <= cmd;
    in_ch.page_number <= dpcm_pkg::PAGE_W'(page);
    in_ch.run_pages   <= dpcm_pkg::RUN_W'(n);
    do @(posedge clk); while (!in_ch.ready);
    predict_command(cmd, page, n);
    if (typed) begin
      r = expected_results.pop_back();
      r.status = st;
      r.page = dpcm_pkg::PAGE_W'(page_out);
      r.frame = dpcm_pkg::FRAME_W'(frame_out);
      expected_results.push_back(r);
    end
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected item has come back
  task automatic drain;
    in_ch.valid <= 0;
    wait (expected_results.size() == 0);
    @(posedge clk);
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result monitor with random backpressure
  initial begin
    int gap;
    page_result_t e;
    out_ch.ready = 0;
    @(posedge clk);
    out_ch.ready <= 1;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected, page %0d", out_ch.page_out);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, out_ch.status);
          check_field("page_out", e.page, out_ch.page_out);
          check_field("frame_out", e.frame, out_ch.frame_out);
          check_field("loaded_from_swap", e.loaded, out_ch.loaded_from_swap);
          check_field("victim_valid", e.vic_valid, out_ch.victim_valid);
          check_field("victim_page", e.vic_page, out_ch.victim_page);
          check_field("victim_written_back", e.vic_wb, out_ch.victim_written_back);
          check_field("last_of_run", e.last, out_ch.last_of_run);
          check_field("hit_total", e.hits, out_ch.hit_total);
          check_field("miss_total", e.misses, out_ch.miss_total);
          check_field("writeback_total", e.writebacks, out_ch.writeback_total);
        end
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
          out_ch.ready <= 0;
          repeat (gap) @(posedge clk);
          out_ch.ready <= 1;
        end
      end
    end
  end

  // random command with mostly well-formed content
  task automatic random_item(int max_mapped, int max_run);
    int pick;
    int page;
    pick = $urandom_range(0, 99);
    if (pick < 30 && mapped_pages > max_mapped) pick = 40;
    if (pick < 5) begin
      page = $urandom_range(0, 1) ? 0 : $urandom_range(RUN_MAX + 1, 63);
      send_item(dpcm_pkg::CMD_ALLOC, $urandom_range(0, PAGES - 1), page);
    end else if (pick < 30) begin
      send_item(dpcm_pkg::CMD_ALLOC, $urandom_range(0, PAGES - 1),
                $urandom_range(0, 7) == 0 ? $urandom_range(1, max_run)
                                          : $urandom_range(1, 6));
    end else if (pick < 50) begin
      if (run_starts.size() > 0 && $urandom_range(0, 9) != 0)
        page = run_starts[$urandom_range(0, run_starts.size() - 1)];
      else
        page = $urandom_range(0, PAGES - 1);
      send_item(dpcm_pkg::CMD_FREE, page, $urandom_range(0, 63));
    end else begin
      page = $urandom_range(0, 9) == 0 ? $urandom_range(0, PAGES - 1)
             : $urandom_range(0, top_page < PAGES - 1 ? top_page + 1 : PAGES - 1);
      send_item($urandom_range(0, 1) ? dpcm_pkg::CMD_WRITE : dpcm_pkg::CMD_READ,
                page, $urandom_range(0, 63));
    end
  endtask

  // stimulus
  initial begin
    stim_row_t rows[$];
    rows = '{
      '{dpcm_pkg::CMD_READ,  0,    1,  1, dpcm_pkg::ST_BAD_PAGE, 0,    0},
      '{dpcm_pkg::CMD_WRITE, 8191, 63, 1, dpcm_pkg::ST_BAD_PAGE, 8191, 0},
      '{dpcm_pkg::CMD_FREE,  8191, 0,  1, dpcm_pkg::ST_BAD_PAGE, 8191, 0},
      '{dpcm_pkg::CMD_ALLOC, 0,    0,  1, dpcm_pkg::ST_NO_SPACE, 0,    0},
      '{dpcm_pkg::CMD_ALLOC, 0,    33, 1, dpcm_pkg::ST_NO_SPACE, 0,    0},
      '{dpcm_pkg::CMD_ALLOC, 8191, 63, 1, dpcm_pkg::ST_NO_SPACE, 0,    0},
      '{dpcm_pkg::CMD_ALLOC, 0,    1,  1, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_READ,  0,    0,  1, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_WRITE, 0,    0,  1, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_ALLOC, 4095, 32, 0, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_FREE,  5,    0,  1, dpcm_pkg::ST_BAD_PAGE, 5,    0},
      '{dpcm_pkg::CMD_FREE,  1,    0,  1, dpcm_pkg::ST_OK,       1,    0},
      '{dpcm_pkg::CMD_READ,  2,    0,  1, dpcm_pkg::ST_BAD_PAGE, 2,    0},
      '{dpcm_pkg::CMD_ALLOC, 0,    4,  0, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_WRITE, 3,    0,  0, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_READ,  4,    0,  0, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_FREE,  0,    0,  1, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_ALLOC, 0,    1,  0, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_WRITE, 4096, 0,  1, dpcm_pkg::ST_BAD_PAGE, 4096, 0},
      '{dpcm_pkg::CMD_ALLOC, 0,    31, 0, dpcm_pkg::ST_OK,       0,    0},
      '{dpcm_pkg::CMD_READ,  5461, 0,  1, dpcm_pkg::ST_BAD_PAGE, 5461, 0},
      '{dpcm_pkg::CMD_FREE,  2730, 0,  1, dpcm_pkg::ST_BAD_PAGE, 2730, 0}
    };
    in_ch.valid = 0;
    in_ch.command = dpcm_pkg::CMD_READ;
    in_ch.page_number = 0;
    in_ch.run_pages = 0;
    hand = dpcm_pkg::FRAME_W'(FRAMES - 1);
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed rows
    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].page, rows[i].run, rows[i].typed,
                rows[i].status, rows[i].page_out, rows[i].frame_out);
    drain();

    // random mix, working set kept small so scans stay short
    for (int i = 0; i < 420; i++) begin
      quiet = (i / 70) % 3 == 2;
      random_item(256, RUN_MAX);
      if (i == 200) drain();
    end
    quiet = 0;

    // fill every frame, then run with clock replacement
    while (mapped_pages < FRAMES + 64)
      send_item(dpcm_pkg::CMD_ALLOC, $urandom_range(0, PAGES - 1), RUN_MAX);
    for (int i = 0; i < 80; i++) begin
      quiet = i >= 60;
      random_item(FRAMES + 200, 4);
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // overall limit
  initial begin
    #400_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
